/* rtl/tbp_pkg.sv */
// Shared types, codes and the note period table of the tracker bytecode player.
package tbp_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_SIZE  = 1 << ADDR_BITS;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_TICK    = 2'd2;

    // pattern opcodes
    localparam logic [7:0] OP_JUMP     = 8'h80;
    localparam logic [7:0] OP_CALL     = 8'h81;
    localparam logic [7:0] OP_LOOP     = 8'h82;
    localparam logic [7:0] OP_LOOP_END = 8'h83;
    localparam logic [7:0] OP_NOISE    = 8'h84;
    localparam logic [7:0] OP_MIXER    = 8'h85;
    localparam logic [7:0] OP_ORN      = 8'h86;
    localparam logic [7:0] OP_SAMPLE   = 8'h87;
    localparam logic [7:0] OP_TRANS    = 8'h88;
    localparam logic [7:0] OP_RET      = 8'h89;
    localparam logic [7:0] OP_HOLD_ON  = 8'h8A;
    localparam logic [7:0] OP_HOLD_OFF = 8'h8B;
    localparam logic [7:0] OP_SKIP3    = 8'h8C;
    localparam logic [7:0] OP_NOISE_ADD = 8'h8D;
    localparam logic [7:0] OP_TRANS_ADD = 8'h8E;
    localparam logic [7:0] OP_TRANS_PUSH = 8'h8F;
    localparam logic [7:0] OP_TRANS_POP = 8'h90;
    localparam logic [7:0] OP_NOTE_MAX = 8'h7F;

    // sample and ornament opcodes
    localparam logic [7:0] SOP_VOL_MAX   = 8'h1D;
    localparam logic [7:0] SOP_VOL_BIAS  = 8'h32;
    localparam logic [7:0] OOP_NOTE_ON   = 8'h82;
    localparam logic [7:0] OOP_NOTE_OFF  = 8'h83;
    localparam logic [7:0] OOP_MIX_TOG   = 8'h84;
    localparam logic [7:0] MIX_TOGGLE    = 8'h09;

    localparam int FLAG_ARM  = 0;
    localparam int FLAG_HOLD = 1;
    localparam int FLAG_ORN  = 2;

    localparam logic [7:0] TOP_NOTE = 8'h53;

    typedef enum logic [25:0] {
        S_IDLE    = 26'h0000001,
        S_RST_RD0 = 26'h0000002,
        S_RST_RD1 = 26'h0000004,
        S_RST_RD2 = 26'h0000008,
        S_T_START = 26'h0000010,
        S_P_RD0   = 26'h0000020,
        S_P_RD1   = 26'h0000040,
        S_P_RD2   = 26'h0000080,
        S_P_EXEC  = 26'h0000100,
        S_P_PUSH2 = 26'h0000200,
        S_N_RD0   = 26'h0000400,
        S_N_RD1   = 26'h0000800,
        S_N_RD2   = 26'h0001000,
        S_E_START = 26'h0002000,
        S_S_RD0   = 26'h0004000,
        S_S_RD1   = 26'h0008000,
        S_S_RD2   = 26'h0010000,
        S_S_EXEC  = 26'h0020000,
        S_O_CHECK = 26'h0040000,
        S_O_RD0   = 26'h0080000,
        S_O_RD1   = 26'h0100000,
        S_O_RD2   = 26'h0200000,
        S_O_EXEC  = 26'h0400000,
        S_AMP     = 26'h0800000,
        S_NEXT    = 26'h1000000,
        S_OUT     = 26'h2000000
    } t_state;

    localparam logic [15:0] NOTE_ROM [84] = '{
        16'h0FBF, 16'h0EDC, 16'h0E07, 16'h0D3D, 16'h0C7F, 16'h0BCC, 16'h0B22, 16'h0A82,
        16'h09EB, 16'h095D, 16'h08D6, 16'h0857, 16'h07DF, 16'h076E, 16'h0703, 16'h069F,
        16'h0640, 16'h05E6, 16'h0591, 16'h0541, 16'h04F6, 16'h04AE, 16'h046B, 16'h042C,
        16'h03F0, 16'h03B7, 16'h0382, 16'h034F, 16'h0320, 16'h02F3, 16'h02C8, 16'h02A1,
        16'h027B, 16'h0257, 16'h0236, 16'h0216, 16'h01F8, 16'h01DC, 16'h01C1, 16'h01A8,
        16'h0190, 16'h0179, 16'h0164, 16'h0150, 16'h013D, 16'h012C, 16'h011B, 16'h010B,
        16'h00FC, 16'h00EE, 16'h00E0, 16'h00D4, 16'h00C8, 16'h00BD, 16'h00B2, 16'h00A8,
        16'h009F, 16'h0096, 16'h008D, 16'h0085, 16'h007E, 16'h0077, 16'h0070, 16'h006A,
        16'h0064, 16'h005E, 16'h0059, 16'h0054, 16'h004F, 16'h004B, 16'h0047, 16'h0043,
        16'h003F, 16'h003B, 16'h0038, 16'h0035, 16'h0032, 16'h002F, 16'h002D, 16'h002A,
        16'h0028, 16'h0025, 16'h0023, 16'h0021
    };

    function automatic logic [15:0] period_of(input logic [7:0] note);
        logic [6:0] idx;
        idx = (note > TOP_NOTE) ? TOP_NOTE[6:0] : note[6:0];
        return NOTE_ROM[idx];
    endfunction

endpackage

/* rtl/tracker_bytecode_player_top.sv */
// Tracker bytecode player: module memory, three channel interpreters, one result per tick.
//
//  channel   direction  handshake                 payload
//  in        in         i_in_valid / o_in_stall   i_func, i_load_address, i_load_byte
//  out       out        o_out_valid / i_out_stall tones, amps, mixer, noise, limit flag
//  cfg       in         i_cfg_we                  i_cfg_data (header address)
//
// Load item: one byte written to module memory. Restart item: six header byte reads.
// Tick item: per channel, pattern opcodes and then sample/ornament opcodes,
// bounded by OP_LIMIT per walk; every step shares the single module
// memory read port, one byte per cycle. A new item is taken only in idle.
// Reset (synchronous, active low) clears player state; memory holds no reset.
// A finished tick waits in the output register while the next item is taken.
module tracker_bytecode_player_top #(
    parameter int STACK_DEPTH = 16,
    parameter int OP_LIMIT    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_load_address,
    input  logic [7:0]  i_load_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_tone_a,
    output logic [11:0] o_tone_b,
    output logic [11:0] o_tone_c,
    output logic [3:0]  o_amp_a,
    output logic [3:0]  o_amp_b,
    output logic [3:0]  o_amp_c,
    output logic [5:0]  o_mixer_bits,
    output logic [4:0]  o_noise_period,
    output logic        o_op_limit_hit
);

    localparam int LVW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(3 * STACK_DEPTH);
    localparam int NW  = $clog2(OP_LIMIT);
    localparam int SSZ = 3 * STACK_DEPTH;

    tbp_pkg::t_state r_state;
    logic [1:0]  r_ch;
    logic [NW-1:0] r_n;
    logic [7:0]  r_op, r_arg;
    logic [15:0] r_s2, r_s1;
    logic        r_hit;
    logic [15:0] r_hdr;

    logic [15:0] r_pp [3];
    logic [7:0]  r_nw [3];
    logic [7:0]  r_sw [3];
    logic [15:0] r_scur [3];
    logic [15:0] r_ocur [3];
    logic [15:0] r_ostart [3];
    logic [15:0] r_sstart [3];
    logic [7:0]  r_ni [3];
    logic [15:0] r_tone [3];
    logic [7:0]  r_vol [3];
    logic [3:0]  r_amp [3];
    logic [7:0]  r_tr [3];
    logic [2:0]  r_flags [3];
    logic [7:0]  r_mix [3];
    logic [LVW-1:0] r_lv [3];
    logic [7:0]  r_noise;

    logic [7:0]  mem [tbp_pkg::MEM_SIZE];
    logic [7:0]  r_mdata;
    logic [15:0] stk [SSZ];
    logic [15:0] r_sdata;

    logic        r_ovalid;
    logic [11:0] r_tone_a, r_tone_b, r_tone_c;
    logic [3:0]  r_amp_a, r_amp_b, r_amp_c;
    logic [5:0]  r_mixo;
    logic [4:0]  r_noiseo;
    logic        r_hito;

    logic [15:0] w_raddr;
    logic [SIW-1:0] w_sbase, w_s_raddr, w_s_waddr;
    logic        w_s_we;
    logic [15:0] w_s_wdata;
    logic [7:0]  w_rom_idx;
    logic [15:0] w_rom;
    logic        w_accept, w_last, w_load_out;

    logic [15:0] w_pp, w_scur, w_ocur, w_sstart;
    logic [7:0]  w_tr;
    logic [LVW-1:0] w_lv;
    logic        w_room1, w_room2, w_has1, w_has2;
    logic [15:0] w_dec, w_w16;
    logic [7:0]  w_nw_dec, w_sw_dec;

    assign w_pp     = r_pp[r_ch];
    assign w_scur   = r_scur[r_ch];
    assign w_ocur   = r_ocur[r_ch];
    assign w_sstart = r_sstart[r_ch];
    assign w_tr     = r_tr[r_ch];
    assign w_lv     = r_lv[r_ch];
    assign w_room1  = w_lv < LVW'(STACK_DEPTH);
    assign w_room2  = ((LVW+1)'(w_lv) + (LVW+1)'(2)) <= (LVW+1)'(STACK_DEPTH);
    assign w_has1   = w_lv >= LVW'(1);
    assign w_has2   = w_lv >= LVW'(2);
    assign w_dec    = r_s2 - 16'd1;
    assign w_w16    = {r_mdata, r_arg};
    assign w_nw_dec = r_nw[r_ch] - 8'd1;
    assign w_sw_dec = r_sw[r_ch] - 8'd1;
    assign w_last   = (r_n == NW'(OP_LIMIT - 1));
    assign w_sbase  = SIW'(r_ch) * SIW'(STACK_DEPTH);

    assign o_in_stall = (r_state != tbp_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load_out = (r_state == tbp_pkg::S_OUT) && (!r_ovalid || !i_out_stall);

    // memory read address follows the sequencer step
    always_comb begin
        case (r_state)
            tbp_pkg::S_RST_RD0: w_raddr = r_hdr + {13'd0, r_ch, 1'b0};
            tbp_pkg::S_RST_RD1: w_raddr = r_hdr + {13'd0, r_ch, 1'b0} + 16'd1;
            tbp_pkg::S_P_RD0:   w_raddr = w_pp;
            tbp_pkg::S_P_RD1:   w_raddr = w_pp + 16'd1;
            tbp_pkg::S_P_RD2:   w_raddr = w_pp + 16'd2;
            tbp_pkg::S_N_RD0:   w_raddr = w_sstart;
            tbp_pkg::S_N_RD1:   w_raddr = w_sstart + 16'd1;
            tbp_pkg::S_S_RD0:   w_raddr = w_scur;
            tbp_pkg::S_S_RD1:   w_raddr = w_scur + 16'd1;
            tbp_pkg::S_S_RD2:   w_raddr = w_scur + 16'd2;
            tbp_pkg::S_O_RD0:   w_raddr = w_ocur;
            tbp_pkg::S_O_RD1:   w_raddr = w_ocur + 16'd1;
            tbp_pkg::S_O_RD2:   w_raddr = w_ocur + 16'd2;
            default:            w_raddr = 16'd0;
        endcase
    end

    // call stack port: reads of the two top entries during fetch, one write per cycle
    always_comb begin
        w_s_raddr = w_sbase;
        if (r_state == tbp_pkg::S_P_RD0 && w_has2)
            w_s_raddr = w_sbase + SIW'(w_lv - LVW'(2));
        else if (r_state == tbp_pkg::S_P_RD1 && w_has1)
            w_s_raddr = w_sbase + SIW'(w_lv - LVW'(1));
        w_s_we    = 1'b0;
        w_s_waddr = w_sbase + SIW'(w_lv);
        w_s_wdata = w_pp + 16'd3;
        if (r_state == tbp_pkg::S_P_EXEC) begin
            case (r_op)
                tbp_pkg::OP_CALL: begin
                    w_s_we = w_room1;
                end
                tbp_pkg::OP_LOOP: begin
                    w_s_we    = w_room2;
                    w_s_wdata = {8'd0, r_arg};
                end
                tbp_pkg::OP_LOOP_END: begin
                    w_s_we    = w_has2;
                    w_s_waddr = w_sbase + SIW'(w_lv - LVW'(2));
                    w_s_wdata = w_dec;
                end
                tbp_pkg::OP_TRANS_PUSH: begin
                    w_s_we    = w_room1;
                    w_s_wdata = {{8{w_tr[7]}}, w_tr};
                end
                default: w_s_we = 1'b0;
            endcase
        end else if (r_state == tbp_pkg::S_P_PUSH2) begin
            w_s_we    = 1'b1;
            w_s_waddr = w_sbase + SIW'(w_lv) + SIW'(1);
            w_s_wdata = w_pp;
        end
    end

    always_comb begin
        if (r_state == tbp_pkg::S_O_EXEC)
            w_rom_idx = r_ni[r_ch] + r_op;
        else
            w_rom_idx = r_op - 8'd1 + w_tr;
    end
    assign w_rom = tbp_pkg::period_of(w_rom_idx);

    always_ff @(posedge i_clk) begin
        if (w_accept && i_func == tbp_pkg::FUNC_LOAD)
            mem[i_load_address] <= i_load_byte;
        r_mdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we)
            stk[w_s_waddr] <= w_s_wdata;
        r_sdata <= stk[w_s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= 16'd0;
        end else if (i_cfg_we) begin
            r_hdr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_tone_a <= r_tone[0][11:0];
            r_tone_b <= r_tone[1][11:0];
            r_tone_c <= r_tone[2][11:0];
            r_amp_a  <= r_amp[0];
            r_amp_b  <= r_amp[1];
            r_amp_c  <= r_amp[2];
            r_mixo   <= r_mix[0][5:0] | {r_mix[1][4:0], 1'b0} | {r_mix[2][3:0], 2'b00};
            r_noiseo <= r_noise[4:0];
            r_hito   <= r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_func == tbp_pkg::FUNC_RESTART)) begin
            for (int c = 0; c < 3; c++) begin
                r_pp[c] <= 16'd0;     r_nw[c] <= 8'd1;      r_sw[c] <= 8'd0;
                r_scur[c] <= 16'd0;   r_ocur[c] <= 16'd0;   r_ostart[c] <= 16'd0;
                r_sstart[c] <= 16'd0; r_ni[c] <= 8'd0;      r_tone[c] <= 16'd0;
                r_vol[c] <= 8'd0;     r_amp[c] <= 4'd0;     r_tr[c] <= 8'd0;
                r_flags[c] <= 3'd0;   r_mix[c] <= 8'd8;     r_lv[c] <= '0;
            end
            r_noise <= 8'd0;
            r_hit   <= 1'b0;
            r_n     <= '0;
            r_ch    <= 2'd0;
            r_state <= i_rst_n ? tbp_pkg::S_RST_RD0 : tbp_pkg::S_IDLE;
        end else begin
            case (r_state)
                tbp_pkg::S_IDLE: begin
                    if (w_accept && i_func == tbp_pkg::FUNC_TICK) begin
                        r_ch    <= 2'd0;
                        r_hit   <= 1'b0;
                        r_state <= tbp_pkg::S_T_START;
                    end
                end
                tbp_pkg::S_RST_RD0: r_state <= tbp_pkg::S_RST_RD1;
                tbp_pkg::S_RST_RD1: begin
                    r_arg   <= r_mdata;
                    r_state <= tbp_pkg::S_RST_RD2;
                end
                tbp_pkg::S_RST_RD2: begin
                    r_pp[r_ch] <= {r_mdata, r_arg};
                    if (r_ch == 2'd2) begin
                        r_state <= tbp_pkg::S_IDLE;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= tbp_pkg::S_RST_RD0;
                    end
                end
                tbp_pkg::S_T_START: begin
                    r_nw[r_ch] <= w_nw_dec;
                    r_n        <= '0;
                    r_state    <= (w_nw_dec != 8'd0) ? tbp_pkg::S_E_START
                                                     : tbp_pkg::S_P_RD0;
                end
                tbp_pkg::S_P_RD0: r_state <= tbp_pkg::S_P_RD1;
                tbp_pkg::S_P_RD1: begin
                    r_op    <= r_mdata;
                    r_s2    <= r_sdata;
                    r_state <= tbp_pkg::S_P_RD2;
                end
                tbp_pkg::S_P_RD2: begin
                    r_arg   <= r_mdata;
                    r_s1    <= r_sdata;
                    r_state <= tbp_pkg::S_P_EXEC;
                end
                tbp_pkg::S_P_EXEC: begin
                    if (r_op <= tbp_pkg::OP_NOTE_MAX) begin
                        logic [2:0] fl;
                        fl = r_flags[r_ch];
                        if (r_op != 8'd0) begin
                            r_ni[r_ch]   <= w_rom_idx;
                            r_tone[r_ch] <= w_rom;
                            fl[tbp_pkg::FLAG_ORN] = 1'b0;
                        end else begin
                            r_tone[r_ch] <= 16'd0;
                        end
                        r_nw[r_ch]   <= r_arg;
                        r_pp[r_ch]   <= w_pp + 16'd2;
                        r_ocur[r_ch] <= r_ostart[r_ch];
                        if (!fl[tbp_pkg::FLAG_HOLD]) begin
                            if (fl[tbp_pkg::FLAG_ARM]) fl[tbp_pkg::FLAG_HOLD] = 1'b1;
                            r_state <= tbp_pkg::S_N_RD0;
                        end else begin
                            r_state <= tbp_pkg::S_E_START;
                        end
                        r_flags[r_ch] <= fl;
                    end else begin
                        case (r_op)
                            tbp_pkg::OP_JUMP: r_pp[r_ch] <= w_w16;
                            tbp_pkg::OP_CALL: begin
                                if (w_room1) r_lv[r_ch] <= w_lv + LVW'(1);
                                r_pp[r_ch] <= w_w16;
                            end
                            tbp_pkg::OP_LOOP: r_pp[r_ch] <= w_pp + 16'd2;
                            tbp_pkg::OP_LOOP_END: begin
                                if (!w_has2) begin
                                    r_pp[r_ch] <= w_pp + 16'd1;
                                end else if (w_dec[7:0] != 8'd0) begin
                                    r_pp[r_ch] <= r_s1;
                                end else begin
                                    r_lv[r_ch] <= w_lv - LVW'(2);
                                    r_pp[r_ch] <= w_pp + 16'd1;
                                end
                            end
                            tbp_pkg::OP_NOISE: begin
                                r_noise    <= r_arg;
                                r_pp[r_ch] <= w_pp + 16'd2;
                            end
                            tbp_pkg::OP_MIXER: begin
                                r_mix[r_ch] <= r_arg;
                                r_pp[r_ch]  <= w_pp + 16'd2;
                            end
                            tbp_pkg::OP_ORN: begin
                                r_ostart[r_ch] <= w_w16;
                                r_pp[r_ch]     <= w_pp + 16'd3;
                            end
                            tbp_pkg::OP_SAMPLE: begin
                                r_sstart[r_ch] <= w_w16;
                                r_pp[r_ch]     <= w_pp + 16'd3;
                            end
                            tbp_pkg::OP_TRANS: begin
                                r_tr[r_ch] <= r_arg;
                                r_pp[r_ch] <= w_pp + 16'd2;
                            end
                            tbp_pkg::OP_RET: begin
                                if (w_has1) begin
                                    r_pp[r_ch] <= r_s1;
                                    r_lv[r_ch] <= w_lv - LVW'(1);
                                end else begin
                                    r_pp[r_ch] <= w_pp + 16'd1;
                                end
                            end
                            tbp_pkg::OP_HOLD_ON: begin
                                r_flags[r_ch][tbp_pkg::FLAG_ARM]  <= 1'b1;
                                r_flags[r_ch][tbp_pkg::FLAG_HOLD] <= 1'b0;
                                r_pp[r_ch] <= w_pp + 16'd1;
                            end
                            tbp_pkg::OP_HOLD_OFF: begin
                                r_flags[r_ch][tbp_pkg::FLAG_ARM]  <= 1'b0;
                                r_flags[r_ch][tbp_pkg::FLAG_HOLD] <= 1'b0;
                                r_pp[r_ch] <= w_pp + 16'd1;
                            end
                            tbp_pkg::OP_SKIP3: r_pp[r_ch] <= w_pp + 16'd3;
                            tbp_pkg::OP_NOISE_ADD: begin
                                r_noise    <= (r_noise + r_arg) & 8'd31;
                                r_pp[r_ch] <= w_pp + 16'd2;
                            end
                            tbp_pkg::OP_TRANS_ADD: begin
                                r_tr[r_ch] <= w_tr + r_arg;
                                r_pp[r_ch] <= w_pp + 16'd2;
                            end
                            tbp_pkg::OP_TRANS_PUSH: begin
                                if (w_room1) r_lv[r_ch] <= w_lv + LVW'(1);
                                r_pp[r_ch] <= w_pp + 16'd1;
                            end
                            tbp_pkg::OP_TRANS_POP: begin
                                if (w_has1) begin
                                    r_tr[r_ch] <= r_s1[7:0];
                                    r_lv[r_ch] <= w_lv - LVW'(1);
                                end
                                r_pp[r_ch] <= w_pp + 16'd1;
                            end
                            default: r_pp[r_ch] <= w_pp + 16'd1;
                        endcase
                        if (r_op == tbp_pkg::OP_LOOP && w_room2) begin
                            r_state <= tbp_pkg::S_P_PUSH2;
                        end else if (w_last) begin
                            r_nw[r_ch] <= 8'd1;
                            r_hit      <= 1'b1;
                            r_state    <= tbp_pkg::S_AMP;
                        end else begin
                            r_n     <= r_n + NW'(1);
                            r_state <= tbp_pkg::S_P_RD0;
                        end
                    end
                end
                tbp_pkg::S_P_PUSH2: begin
                    r_lv[r_ch] <= w_lv + LVW'(2);
                    if (w_last) begin
                        r_nw[r_ch] <= 8'd1;
                        r_hit      <= 1'b1;
                        r_state    <= tbp_pkg::S_AMP;
                    end else begin
                        r_n     <= r_n + NW'(1);
                        r_state <= tbp_pkg::S_P_RD0;
                    end
                end
                tbp_pkg::S_N_RD0: r_state <= tbp_pkg::S_N_RD1;
                tbp_pkg::S_N_RD1: begin
                    r_vol[r_ch] <= r_mdata;
                    r_state     <= tbp_pkg::S_N_RD2;
                end
                tbp_pkg::S_N_RD2: begin
                    r_sw[r_ch]   <= r_mdata;
                    r_scur[r_ch] <= w_sstart + 16'd2;
                    r_state      <= tbp_pkg::S_AMP;
                end
                tbp_pkg::S_E_START: begin
                    r_sw[r_ch] <= w_sw_dec;
                    r_n        <= '0;
                    r_state    <= (w_sw_dec == 8'd0) ? tbp_pkg::S_S_RD0
                                                     : tbp_pkg::S_O_CHECK;
                end
                tbp_pkg::S_S_RD0: r_state <= tbp_pkg::S_S_RD1;
                tbp_pkg::S_S_RD1: begin
                    r_op    <= r_mdata;
                    r_state <= tbp_pkg::S_S_RD2;
                end
                tbp_pkg::S_S_RD2: begin
                    r_arg   <= r_mdata;
                    r_state <= tbp_pkg::S_S_EXEC;
                end
                tbp_pkg::S_S_EXEC: begin
                    if (r_op <= tbp_pkg::SOP_VOL_MAX) begin
                        r_vol[r_ch]  <= r_op;
                        r_sw[r_ch]   <= r_arg;
                        r_scur[r_ch] <= w_scur + 16'd2;
                        r_state      <= tbp_pkg::S_O_CHECK;
                    end else if (r_op == tbp_pkg::OP_JUMP) begin
                        r_scur[r_ch] <= w_w16;
                        if (w_last) begin
                            r_sw[r_ch] <= 8'd1;
                            r_hit      <= 1'b1;
                            r_state    <= tbp_pkg::S_O_CHECK;
                        end else begin
                            r_n     <= r_n + NW'(1);
                            r_state <= tbp_pkg::S_S_RD0;
                        end
                    end else begin
                        r_vol[r_ch]  <= r_op - tbp_pkg::SOP_VOL_BIAS;
                        r_scur[r_ch] <= w_scur + 16'd1;
                        r_sw[r_ch]   <= 8'd1;
                        r_state      <= tbp_pkg::S_O_CHECK;
                    end
                end
                tbp_pkg::S_O_CHECK: begin
                    r_n     <= '0;
                    r_state <= (r_tone[r_ch] != 16'd0) ? tbp_pkg::S_O_RD0 : tbp_pkg::S_AMP;
                end
                tbp_pkg::S_O_RD0: r_state <= tbp_pkg::S_O_RD1;
                tbp_pkg::S_O_RD1: begin
                    r_op    <= r_mdata;
                    r_state <= tbp_pkg::S_O_RD2;
                end
                tbp_pkg::S_O_RD2: begin
                    r_arg   <= r_mdata;
                    r_state <= tbp_pkg::S_O_EXEC;
                end
                tbp_pkg::S_O_EXEC: begin
                    if (r_op == tbp_pkg::OP_JUMP) begin
                        r_ocur[r_ch] <= w_w16;
                    end else begin
                        r_ocur[r_ch] <= w_ocur + 16'd1;
                    end
                    if (r_op == tbp_pkg::OOP_NOTE_ON)
                        r_flags[r_ch][tbp_pkg::FLAG_ORN] <= 1'b1;
                    if (r_op == tbp_pkg::OOP_NOTE_OFF)
                        r_flags[r_ch][tbp_pkg::FLAG_ORN] <= 1'b0;
                    if (r_op == tbp_pkg::OOP_MIX_TOG)
                        r_mix[r_ch] <= r_mix[r_ch] ^ tbp_pkg::MIX_TOGGLE;
                    if (r_op == tbp_pkg::OP_JUMP || r_op == tbp_pkg::OOP_NOTE_ON ||
                        r_op == tbp_pkg::OOP_NOTE_OFF || r_op == tbp_pkg::OOP_MIX_TOG) begin
                        if (w_last) begin
                            r_hit   <= 1'b1;
                            r_state <= tbp_pkg::S_AMP;
                        end else begin
                            r_n     <= r_n + NW'(1);
                            r_state <= tbp_pkg::S_O_RD0;
                        end
                    end else begin
                        if (r_flags[r_ch][tbp_pkg::FLAG_ORN]) begin
                            r_ni[r_ch]   <= w_rom_idx;
                            r_tone[r_ch] <= w_rom;
                        end else begin
                            r_tone[r_ch] <= r_tone[r_ch] + {{8{r_op[7]}}, r_op};
                        end
                        r_state <= tbp_pkg::S_AMP;
                    end
                end
                tbp_pkg::S_AMP: begin
                    r_amp[r_ch] <= (r_tone[r_ch] != 16'd0) ? r_vol[r_ch][3:0] : 4'd0;
                    r_state     <= tbp_pkg::S_NEXT;
                end
                tbp_pkg::S_NEXT: begin
                    if (r_ch == 2'd2) begin
                        r_state <= tbp_pkg::S_OUT;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= tbp_pkg::S_T_START;
                    end
                end
                tbp_pkg::S_OUT: begin
                    if (w_load_out) r_state <= tbp_pkg::S_IDLE;
                end
                default: r_state <= tbp_pkg::S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_tone_a       = r_tone_a;
    assign o_tone_b       = r_tone_b;
    assign o_tone_c       = r_tone_c;
    assign o_amp_a        = r_amp_a;
    assign o_amp_b        = r_amp_b;
    assign o_amp_c        = r_amp_c;
    assign o_mixer_bits   = r_mixo;
    assign o_noise_period = r_noiseo;
    assign o_op_limit_hit = r_hito;

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch != 2'd3) |-> (r_lv[r_ch] <= LVW'(STACK_DEPTH)))
        else $error("call stack level above depth");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch != 2'd3)
        else $error("channel index out of range");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == tbp_pkg::FUNC_TICK) |=>
            (r_state == tbp_pkg::S_T_START && r_ch == 2'd0 && !r_hit))
        else $error("tick item did not start channel A");

    a_out_only_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == tbp_pkg::S_OUT))
        else $error("result raised outside the output step");

endmodule
